// ===== rtl/barycentric_zbuffer_pixel_macros.svh =====
// Assertion macros shared by the barycentric z-buffer pixel RTL.
`ifndef BARYCENTRIC_ZBUFFER_PIXEL_MACROS_SVH
`define BARYCENTRIC_ZBUFFER_PIXEL_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define BZP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define BZP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bzp_pkg.sv =====
// Shared types, widths and field offsets for the barycentric z-buffer pixel block.
`default_nettype none

package bzp_pkg;

    // Canvas defaults
    localparam int IMAGE_WIDTH_DEF  = 128;
    localparam int IMAGE_HEIGHT_DEF = 128;

    // Field widths
    localparam int CRD_W   = 12;   // vertex screen coordinate
    localparam int DZ_W    = 16;   // Q1.14 depth
    localparam int PIX_W   = 7;    // pixel column / row
    localparam int COLOR_W = 24;   // packed RGB

    // Datapath widths
    localparam int DIF_W   = 13;   // vertex differences
    localparam int WGT_W   = 26;   // raw weights and determinant
    localparam int WA_W    = 28;   // weight of A before the sign check
    localparam int DIV_W   = 25;   // positive determinant magnitude
    localparam int ACC_W   = 42;   // multiply-accumulate result
    localparam int DIV_STEPS = DZ_W; // quotient bits

    localparam logic signed [DZ_W-1:0] DEPTH_MIN = 16'sh8000;

    // Input tdata layout
    localparam int AX_LSB    = 0;
    localparam int AY_LSB    = 12;
    localparam int AZ_LSB    = 24;
    localparam int BX_LSB    = 40;
    localparam int BY_LSB    = 52;
    localparam int BZ_LSB    = 64;
    localparam int CX_LSB    = 80;
    localparam int CY_LSB    = 92;
    localparam int CZ_LSB    = 104;
    localparam int PX_LSB    = 120;
    localparam int PY_LSB    = 127;
    localparam int COLOR_LSB = 134;
    localparam int IN_W      = 160;

    // Output tdata layout
    localparam int OUT_PAD = 2;
    localparam int OUT_W   = 56;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_U0,
        S_U1,
        S_V0,
        S_V1,
        S_D0,
        S_D1,
        S_NORM,
        S_Z0,
        S_Z1,
        S_Z2,
        S_DIVS,
        S_DIVW,
        S_CMP
    } t_state;

    typedef enum logic [3:0] {
        MUL_X1Y2,
        MUL_X2Y1,
        MUL_X2Y0,
        MUL_X0Y2,
        MUL_X0Y1,
        MUL_X1Y0,
        MUL_AZW,
        MUL_BZV,
        MUL_CZU
    } t_mul_sel;

    typedef enum logic [1:0] {
        ST_NONE,
        ST_U,
        ST_V,
        ST_D
    } t_store;

    typedef struct packed {
        logic     accept;
        logic     clear_step;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     mul_first;
        logic     mul_sub;
        t_store   store;
        logic     norm;
        logic     div_start;
        logic     finish;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic reject;
        logic div_done;
        logic out_busy;
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/barycentric_zbuffer_pixel.sv =====
// Top level of the barycentric triangle pixel stage with depth store.
// A rejected pixel skips the divider and the later depth products; the block takes one item at
// a time, and a result not yet taken holds the next. One shared 16x26 multiplier steps through
// nine products (seven when rejected) and a radix-2 divider gives one quotient bit per cycle.
// Reset: synchronous, active low; then a clearing pass writes minimum depth to every one of the
// IMAGE_WIDTH*IMAGE_HEIGHT entries (16384 by default) while s_axis_tready stays low.
`default_nettype none

module barycentric_zbuffer_pixel #(
    parameter int IMAGE_WIDTH  = bzp_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = bzp_pkg::IMAGE_HEIGHT_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    // ax, ay, az, bx, by, bz, cx, cy, cz, px, py, fill_color, zero pad
    input  wire logic [bzp_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // out_x, out_y, out_color, out_depth, zero pad
    output logic [bzp_pkg::OUT_W-1:0]       m_axis_tdata,
    // write_pixel
    output logic [0:0]                      m_axis_tuser
);

    bzp_pkg::t_cmd    cmd;
    bzp_pkg::t_status status;

    // Sequencer
    bzp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Arithmetic, depth store and result register
    bzp_datapath #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_s_tdata  (s_axis_tdata),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tuser  (m_axis_tuser[0])
    );

endmodule

`default_nettype wire

// ===== rtl/bzp_div.sv =====
// Radix-2 restoring divider for the depth quotient, truncating toward zero.
`default_nettype none

module bzp_div (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic signed [bzp_pkg::ACC_W-1:0]   i_num,
    input  wire logic        [bzp_pkg::DIV_W-1:0]   i_den,
    output logic signed      [bzp_pkg::DZ_W-1:0]    o_quot,
    output logic                                    o_done
);

    `include "barycentric_zbuffer_pixel_macros.svh"

    localparam int CNT_W = $clog2(bzp_pkg::DIV_STEPS);

    logic                            r_busy;
    logic                            r_done;
    logic [CNT_W-1:0]                r_cnt;
    logic                            r_neg;
    logic [bzp_pkg::DIV_W-1:0]       r_rem;
    logic [bzp_pkg::DIV_W-1:0]       r_den;
    logic [bzp_pkg::DIV_STEPS-1:0]   r_lo;

    logic [bzp_pkg::ACC_W-1:0]       mag;
    logic [bzp_pkg::DIV_W:0]         trial;
    logic [bzp_pkg::DIV_W:0]         diff;
    logic                            ge;

    // Take the magnitude of the numerator
    assign mag = i_num[bzp_pkg::ACC_W-1] ? bzp_pkg::ACC_W'(-i_num) : i_num;

    // One quotient bit per step
    assign trial = {r_rem, r_lo[bzp_pkg::DIV_STEPS-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = (trial >= {1'b0, r_den});

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(bzp_pkg::DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Load the operands, then shift and subtract
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[bzp_pkg::ACC_W-1];
            r_den <= i_den;
            r_rem <= mag[bzp_pkg::DIV_STEPS +: bzp_pkg::DIV_W];
            r_lo  <= mag[bzp_pkg::DIV_STEPS-1:0];
        end else if (r_busy) begin
            r_rem <= ge ? diff[bzp_pkg::DIV_W-1:0] : trial[bzp_pkg::DIV_W-1:0];
            r_lo  <= {r_lo[bzp_pkg::DIV_STEPS-2:0], ge};
        end
    end

    // Restore the sign of the quotient
    assign o_quot = r_neg ? -$signed(r_lo) : $signed(r_lo);
    assign o_done = r_done;

    `BZP_ASSERT_NOW(a_rem_below_den, r_busy, r_rem < r_den, "divider remainder not below divisor")
    `BZP_ASSERT_NEXT(a_start_runs, i_start, r_busy && !r_done, "divider did not start")

endmodule

`default_nettype wire

// ===== rtl/bzp_datapath.sv =====
// Datapath: edge terms, shared multiply-accumulate, depth store and result register.
`default_nettype none

module bzp_datapath #(
    parameter int IMAGE_WIDTH  = bzp_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = bzp_pkg::IMAGE_HEIGHT_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire bzp_pkg::t_cmd                  i_cmd,
    output bzp_pkg::t_status                    o_status,
    input  wire logic [bzp_pkg::IN_W-1:0]       i_s_tdata,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic [bzp_pkg::OUT_W-1:0]           o_m_tdata,
    output logic                                o_m_tuser
);

    `include "barycentric_zbuffer_pixel_macros.svh"

    localparam int DEPTH  = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Input field views
    logic signed [bzp_pkg::CRD_W-1:0]   in_ax, in_ay, in_bx, in_by, in_cx, in_cy;
    logic        [bzp_pkg::PIX_W-1:0]   in_px, in_py;
    logic        [31:0]                 in_addr_full;
    logic                               in_on_canvas;

    // Latched item
    logic signed [bzp_pkg::DIF_W-1:0]   r_x0, r_x1, r_x2, r_y0, r_y1, r_y2;
    logic signed [bzp_pkg::DZ_W-1:0]    r_az, r_bz, r_cz;
    logic        [bzp_pkg::PIX_W-1:0]   r_px, r_py;
    logic        [bzp_pkg::COLOR_W-1:0] r_color;
    logic        [ADDR_W-1:0]           r_addr;
    logic                               r_on_canvas;

    // Weights
    logic signed [bzp_pkg::ACC_W-1:0]   r_acc;
    logic signed [bzp_pkg::WGT_W-1:0]   r_u, r_v, r_d;
    logic signed [bzp_pkg::WGT_W-1:0]   r_un, r_vn, r_wn;
    logic        [bzp_pkg::DIV_W-1:0]   r_dn;
    logic                               r_reject;

    // Multiplier
    logic signed [bzp_pkg::DZ_W-1:0]    mul_a;
    logic signed [bzp_pkg::WGT_W-1:0]   mul_b;
    logic signed [bzp_pkg::ACC_W-1:0]   prod;
    logic signed [bzp_pkg::ACC_W-1:0]   acc_base;
    logic signed [bzp_pkg::ACC_W-1:0]   n_acc;

    // Normalization
    logic signed [bzp_pkg::WGT_W-1:0]   nd, nu, nv;
    logic signed [bzp_pkg::WA_W-1:0]    nw;
    logic                               n_reject;

    // Depth store
    logic signed [bzp_pkg::DZ_W-1:0]    mem [DEPTH];
    logic signed [bzp_pkg::DZ_W-1:0]    r_mem_q;
    logic        [ADDR_W-1:0]           r_clr_addr;
    logic                               mem_we;
    logic        [ADDR_W-1:0]           mem_waddr;
    logic signed [bzp_pkg::DZ_W-1:0]    mem_wdata;

    // Divider and result
    logic signed [bzp_pkg::DZ_W-1:0]    quot;
    logic                               div_done;
    logic                               draw;
    logic                               r_out_valid;
    logic                               r_out_write;
    logic        [bzp_pkg::PIX_W-1:0]   r_out_x, r_out_y;
    logic        [bzp_pkg::COLOR_W-1:0] r_out_color;
    logic signed [bzp_pkg::DZ_W-1:0]    r_out_depth;

    // Unpack the input transaction
    assign in_ax = i_s_tdata[bzp_pkg::AX_LSB +: bzp_pkg::CRD_W];
    assign in_ay = i_s_tdata[bzp_pkg::AY_LSB +: bzp_pkg::CRD_W];
    assign in_bx = i_s_tdata[bzp_pkg::BX_LSB +: bzp_pkg::CRD_W];
    assign in_by = i_s_tdata[bzp_pkg::BY_LSB +: bzp_pkg::CRD_W];
    assign in_cx = i_s_tdata[bzp_pkg::CX_LSB +: bzp_pkg::CRD_W];
    assign in_cy = i_s_tdata[bzp_pkg::CY_LSB +: bzp_pkg::CRD_W];
    assign in_px = i_s_tdata[bzp_pkg::PX_LSB +: bzp_pkg::PIX_W];
    assign in_py = i_s_tdata[bzp_pkg::PY_LSB +: bzp_pkg::PIX_W];

    assign in_addr_full = 32'(in_py) * 32'(IMAGE_WIDTH) + 32'(in_px);
    assign in_on_canvas = (32'(in_px) < 32'(IMAGE_WIDTH)) && (32'(in_py) < 32'(IMAGE_HEIGHT));

    // Latch edge terms and payload on accept
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_x0        <= bzp_pkg::DIF_W'(in_cx) - bzp_pkg::DIF_W'(in_ax);
            r_x1        <= bzp_pkg::DIF_W'(in_bx) - bzp_pkg::DIF_W'(in_ax);
            r_x2        <= bzp_pkg::DIF_W'(in_ax) - bzp_pkg::DIF_W'($signed({1'b0, in_px}));
            r_y0        <= bzp_pkg::DIF_W'(in_cy) - bzp_pkg::DIF_W'(in_ay);
            r_y1        <= bzp_pkg::DIF_W'(in_by) - bzp_pkg::DIF_W'(in_ay);
            r_y2        <= bzp_pkg::DIF_W'(in_ay) - bzp_pkg::DIF_W'($signed({1'b0, in_py}));
            r_az        <= i_s_tdata[bzp_pkg::AZ_LSB +: bzp_pkg::DZ_W];
            r_bz        <= i_s_tdata[bzp_pkg::BZ_LSB +: bzp_pkg::DZ_W];
            r_cz        <= i_s_tdata[bzp_pkg::CZ_LSB +: bzp_pkg::DZ_W];
            r_px        <= in_px;
            r_py        <= in_py;
            r_color     <= i_s_tdata[bzp_pkg::COLOR_LSB +: bzp_pkg::COLOR_W];
            r_addr      <= in_addr_full[ADDR_W-1:0];
            r_on_canvas <= in_on_canvas;
        end
    end

    // Select multiplier operands
    always_comb begin
        case (i_cmd.mul_sel)
            bzp_pkg::MUL_X1Y2: begin
                mul_a = bzp_pkg::DZ_W'(r_x1);
                mul_b = bzp_pkg::WGT_W'(r_y2);
            end
            bzp_pkg::MUL_X2Y1: begin
                mul_a = bzp_pkg::DZ_W'(r_x2);
                mul_b = bzp_pkg::WGT_W'(r_y1);
            end
            bzp_pkg::MUL_X2Y0: begin
                mul_a = bzp_pkg::DZ_W'(r_x2);
                mul_b = bzp_pkg::WGT_W'(r_y0);
            end
            bzp_pkg::MUL_X0Y2: begin
                mul_a = bzp_pkg::DZ_W'(r_x0);
                mul_b = bzp_pkg::WGT_W'(r_y2);
            end
            bzp_pkg::MUL_X0Y1: begin
                mul_a = bzp_pkg::DZ_W'(r_x0);
                mul_b = bzp_pkg::WGT_W'(r_y1);
            end
            bzp_pkg::MUL_X1Y0: begin
                mul_a = bzp_pkg::DZ_W'(r_x1);
                mul_b = bzp_pkg::WGT_W'(r_y0);
            end
            bzp_pkg::MUL_AZW: begin
                mul_a = r_az;
                mul_b = r_wn;
            end
            bzp_pkg::MUL_BZV: begin
                mul_a = r_bz;
                mul_b = r_vn;
            end
            bzp_pkg::MUL_CZU: begin
                mul_a = r_cz;
                mul_b = r_un;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Multiply and accumulate
    assign prod     = mul_a * mul_b;
    assign acc_base = i_cmd.mul_first ? '0 : r_acc;
    assign n_acc    = i_cmd.mul_sub ? (acc_base - prod) : (acc_base + prod);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_acc <= n_acc;
            case (i_cmd.store)
                bzp_pkg::ST_U:    r_u <= n_acc[bzp_pkg::WGT_W-1:0];
                bzp_pkg::ST_V:    r_v <= n_acc[bzp_pkg::WGT_W-1:0];
                bzp_pkg::ST_D:    r_d <= n_acc[bzp_pkg::WGT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Make the determinant positive and check the weights
    assign nd = r_d[bzp_pkg::WGT_W-1] ? -r_d : r_d;
    assign nu = r_d[bzp_pkg::WGT_W-1] ? -r_u : r_u;
    assign nv = r_d[bzp_pkg::WGT_W-1] ? -r_v : r_v;
    assign nw = bzp_pkg::WA_W'(nd) - bzp_pkg::WA_W'(nu) - bzp_pkg::WA_W'(nv);
    assign n_reject = (r_d == '0) || nu[bzp_pkg::WGT_W-1] || nv[bzp_pkg::WGT_W-1]
                      || nw[bzp_pkg::WA_W-1] || !r_on_canvas;

    always_ff @(posedge i_clk) begin
        if (i_cmd.norm) begin
            r_un     <= nu;
            r_vn     <= nv;
            r_wn     <= nw[bzp_pkg::WGT_W-1:0];
            r_dn     <= nd[bzp_pkg::DIV_W-1:0];
            r_reject <= n_reject;
        end
    end

    // Depth quotient
    bzp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_acc),
        .i_den   (r_dn),
        .o_quot  (quot),
        .o_done  (div_done)
    );

    // Depth test
    assign draw = !r_reject && (r_mem_q < quot);

    // Clearing pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_step) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // Depth store write and read ports
    assign mem_we    = i_cmd.clear_step || (i_cmd.finish && draw);
    assign mem_waddr = i_cmd.clear_step ? r_clr_addr : r_addr;
    assign mem_wdata = i_cmd.clear_step ? bzp_pkg::DEPTH_MIN : quot;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.norm && r_on_canvas) begin
            r_mem_q <= mem[r_addr];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_write <= draw;
            r_out_x     <= draw ? r_px : '0;
            r_out_y     <= draw ? r_py : '0;
            r_out_color <= draw ? r_color : '0;
            r_out_depth <= draw ? quot : '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_write;
    assign o_m_tdata  = {{bzp_pkg::OUT_PAD{1'b0}}, r_out_depth, r_out_color, r_out_y, r_out_x};

    // Status to the controller
    assign o_status.clear_done = (r_clr_addr == ADDR_W'(DEPTH - 1));
    assign o_status.reject     = r_reject;
    assign o_status.div_done   = div_done;
    assign o_status.out_busy   = r_out_valid && !i_m_tready;

    `BZP_ASSERT_NOW(a_no_result_overrun, i_cmd.finish, !(r_out_valid && !i_m_tready), "result register overwritten")
    `BZP_ASSERT_NOW(a_write_on_canvas, i_cmd.finish && draw, r_on_canvas, "depth write off canvas")

endmodule

`default_nettype wire

// ===== rtl/bzp_ctrl.sv =====
// Controller: sequences clearing, weight products, depth interpolation and result load.
`default_nettype none

module bzp_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire bzp_pkg::t_status   i_status,
    output bzp_pkg::t_cmd           o_cmd
);

    bzp_pkg::t_state r_state;
    bzp_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bzp_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bzp_pkg::S_CLEAR: if (i_status.clear_done) n_state = bzp_pkg::S_IDLE;
            bzp_pkg::S_IDLE:  if (i_s_tvalid) n_state = bzp_pkg::S_U0;
            bzp_pkg::S_U0:    n_state = bzp_pkg::S_U1;
            bzp_pkg::S_U1:    n_state = bzp_pkg::S_V0;
            bzp_pkg::S_V0:    n_state = bzp_pkg::S_V1;
            bzp_pkg::S_V1:    n_state = bzp_pkg::S_D0;
            bzp_pkg::S_D0:    n_state = bzp_pkg::S_D1;
            bzp_pkg::S_D1:    n_state = bzp_pkg::S_NORM;
            bzp_pkg::S_NORM:  n_state = bzp_pkg::S_Z0;
            bzp_pkg::S_Z0: begin
                n_state = i_status.reject ? bzp_pkg::S_CMP : bzp_pkg::S_Z1;
            end
            bzp_pkg::S_Z1:    n_state = bzp_pkg::S_Z2;
            bzp_pkg::S_Z2:    n_state = bzp_pkg::S_DIVS;
            bzp_pkg::S_DIVS:  n_state = bzp_pkg::S_DIVW;
            bzp_pkg::S_DIVW:  if (i_status.div_done) n_state = bzp_pkg::S_CMP;
            bzp_pkg::S_CMP:   if (!i_status.out_busy) n_state = bzp_pkg::S_IDLE;
            default:          n_state = bzp_pkg::S_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            bzp_pkg::S_CLEAR: o_cmd.clear_step = 1'b1;
            bzp_pkg::S_IDLE: begin
                o_s_tready   = 1'b1;
                o_cmd.accept = i_s_tvalid;
            end
            bzp_pkg::S_U0: begin
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_sel   = bzp_pkg::MUL_X1Y2;
                o_cmd.mul_first = 1'b1;
            end
            bzp_pkg::S_U1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = bzp_pkg::MUL_X2Y1;
                o_cmd.mul_sub = 1'b1;
                o_cmd.store   = bzp_pkg::ST_U;
            end
            bzp_pkg::S_V0: begin
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_sel   = bzp_pkg::MUL_X2Y0;
                o_cmd.mul_first = 1'b1;
            end
            bzp_pkg::S_V1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = bzp_pkg::MUL_X0Y2;
                o_cmd.mul_sub = 1'b1;
                o_cmd.store   = bzp_pkg::ST_V;
            end
            bzp_pkg::S_D0: begin
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_sel   = bzp_pkg::MUL_X0Y1;
                o_cmd.mul_first = 1'b1;
            end
            bzp_pkg::S_D1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = bzp_pkg::MUL_X1Y0;
                o_cmd.mul_sub = 1'b1;
                o_cmd.store   = bzp_pkg::ST_D;
            end
            bzp_pkg::S_NORM:  o_cmd.norm = 1'b1;
            bzp_pkg::S_Z0: begin
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_sel   = bzp_pkg::MUL_AZW;
                o_cmd.mul_first = 1'b1;
            end
            bzp_pkg::S_Z1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = bzp_pkg::MUL_BZV;
            end
            bzp_pkg::S_Z2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = bzp_pkg::MUL_CZU;
            end
            bzp_pkg::S_DIVS:  o_cmd.div_start = 1'b1;
            bzp_pkg::S_DIVW:  ;
            bzp_pkg::S_CMP:   o_cmd.finish = !i_status.out_busy;
            default:          ;
        endcase
    end

endmodule

`default_nettype wire
